>>> hdl/tfv_pkg.sv
package tfv_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } tfv_in_t;

  typedef struct packed {
    logic       valid_res;
    logic [1:0] error_code;
  } tfv_out_t;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_MATCH = 2'd1;
  localparam logic [1:0] ERR_LUHN  = 2'd2;

  localparam logic [3:0] FMT_EMAIL    = 4'd0;
  localparam logic [3:0] FMT_DATETIME = 4'd1;
  localparam logic [3:0] FMT_DATE     = 4'd2;
  localparam logic [3:0] FMT_TIME     = 4'd3;
  localparam logic [3:0] FMT_HOST     = 4'd4;
  localparam logic [3:0] FMT_IPV4     = 4'd5;
  localparam logic [3:0] FMT_IPV6     = 4'd6;
  localparam logic [3:0] FMT_URI      = 4'd7;
  localparam logic [3:0] FMT_UUID     = 4'd8;
  localparam logic [3:0] FMT_DIGITS   = 4'd9;
  localparam logic [3:0] FMT_PHONE    = 4'd10;
  localparam logic [3:0] FMT_CARD     = 4'd11;

  localparam logic [7:0] S_MIN  = 8'd40;
  localparam logic [7:0] S_SEC1 = 8'd41;
  localparam logic [7:0] S_SEC2 = 8'd42;
  localparam logic [7:0] S_SEC  = 8'd43;
  localparam logic [7:0] S_FR0  = 8'd44;
  localparam logic [7:0] S_FR   = 8'd45;
  localparam logic [7:0] S_TZ   = 8'd46;
  localparam logic [7:0] S_END  = 8'd51;

  typedef struct packed {
    logic [7:0] pos;
    logic [8:0] total;
    logic [6:0] run;
    logic [3:0] grp;
    logic [8:0] octet;
    logic [3:0] lev;
    logic [3:0] lod;
    logic       miss;
  } tfv_state_t;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_alp(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction
  function automatic logic is_aln(input logic [7:0] c);
    return is_dig(c) || is_alp(c);
  endfunction
  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction
  function automatic logic is_spc(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Template classes: 0 digit, 1 hex, 2 literal character.
  function automatic logic tpl_match(input logic [1:0] k, input logic [7:0] lit,
                                     input logic [7:0] c);
    case (k)
      2'd0: return is_dig(c);
      2'd1: return is_hex(c);
      default: return c == lit;
    endcase
  endfunction

  function automatic logic dt_match(input logic [7:0] p, input logic [7:0] c);
    case (p)
      8'd4, 8'd7: return c == "-";
      8'd10: return c == "T";
      8'd13, 8'd16: return c == ":";
      default: return is_dig(c);
    endcase
  endfunction

  function automatic logic uuid_match(input logic [7:0] p, input logic [7:0] c);
    case (p)
      8'd8, 8'd13, 8'd18, 8'd23: return tpl_match(2'd2, "-", c);
      default: return tpl_match(2'd1, 8'h00, c);
    endcase
  endfunction

  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    case (d)
      4'd0: return 4'd0; 4'd1: return 4'd2; 4'd2: return 4'd4; 4'd3: return 4'd6;
      4'd4: return 4'd8; 4'd5: return 4'd1; 4'd6: return 4'd3; 4'd7: return 4'd5;
      4'd8: return 4'd7; default: return 4'd9;
    endcase
  endfunction

  function automatic logic [3:0] mod10(input logic [4:0] v);
    return (v >= 5'd10) ? 4'(v - 5'd10) : v[3:0];
  endfunction

endpackage

>>> hdl/tfv_step.sv
module tfv_step (
  input  logic [3:0]          fmt,
  input  logic [7:0]          c,
  input  tfv_pkg::tfv_state_t cur,
  output tfv_pkg::tfv_state_t nxt,
  output logic                acc
);
  import tfv_pkg::*;

  tfv_state_t s;
  logic       ok;
  logic [7:0] p;
  logic [6:0] run_sat;
  logic [11:0] oct_w;
  logic [3:0] dval;
  logic       loc, dom, auth;

  always_comb begin
    s = cur;
    p = cur.pos;
    ok = 1'b0;
    run_sat = (cur.run < 7'd127) ? cur.run + 7'd1 : cur.run;
    dval = c[3:0];
    oct_w = 12'({cur.octet, 3'b000}) + 12'({cur.octet, 1'b0}) + 12'(dval);
    loc = is_aln(c) || c == "." || c == "_" || c == "%" || c == "+" || c == "-";
    dom = is_aln(c) || c == "." || c == "-";
    auth = !is_spc(c) && c != "/";
    if (cur.total < 9'd511) s.total = cur.total + 9'd1;
    case (fmt)
      FMT_EMAIL: begin
        case (p)
          8'd0: begin ok = loc; s.pos = 8'd1; end
          8'd1: begin
            if (c == "@") begin ok = 1'b1; s.pos = 8'd2; end
            else ok = loc;
          end
          8'd2: begin ok = dom; s.pos = 8'd3; s.grp = 4'd0; s.run = 7'd0; end
          8'd3: begin
            ok = dom;
            if (c == ".") begin s.grp = 4'd1; s.run = 7'd0; end
            else if (is_alp(c)) s.run = run_sat;
            else s.grp = 4'd0;
          end
          default: ok = 1'b0;
        endcase
      end
      FMT_DATE: begin
        ok = p < 8'd10 && dt_match(p, c);
        s.pos = p + 8'd1;
      end
      FMT_UUID: begin
        ok = p < 8'd36 && uuid_match(p, c);
        s.pos = p + 8'd1;
      end
      FMT_DATETIME, FMT_TIME: begin
        if ((fmt == FMT_DATETIME && p < 8'd19) || (fmt == FMT_TIME && p < 8'd5)) begin
          ok = (fmt == FMT_DATETIME) ? dt_match(p, c) : dt_match(p + 8'd11, c);
          if (fmt == FMT_DATETIME && p == 8'd18) s.pos = S_SEC;
          else if (fmt == FMT_TIME && p == 8'd4) s.pos = S_MIN;
          else s.pos = p + 8'd1;
        end else if (p >= S_TZ && p < S_END) begin
          ok = (p == S_TZ + 8'd2) ? (c == ":") : is_dig(c);
          s.pos = p + 8'd1;
        end else begin
          case (p)
            S_MIN, S_SEC, S_FR: begin
              ok = 1'b1;
              if (p == S_MIN && c == ":") s.pos = S_SEC1;
              else if (p == S_SEC && c == ".") s.pos = S_FR0;
              else if (p == S_FR && is_dig(c)) s.pos = S_FR;
              else if (c == "Z") s.pos = S_END;
              else if (c == "+" || c == "-") s.pos = S_TZ;
              else ok = 1'b0;
            end
            S_SEC1: begin ok = is_dig(c); s.pos = S_SEC2; end
            S_SEC2: begin ok = is_dig(c); s.pos = S_SEC; end
            S_FR0: begin ok = is_dig(c); s.pos = S_FR; end
            default: ok = 1'b0;
          endcase
        end
      end
      FMT_HOST: begin
        if (c == ".") begin
          ok = p == 8'd1 && cur.grp == 4'd0;
          s.pos = 8'd0; s.run = 7'd0;
        end else begin
          ok = (is_aln(c) || c == "-") && !(c == "-" && p == 8'd0) && run_sat <= 7'd63;
          s.run = run_sat; s.pos = 8'd1; s.grp = {3'd0, c == "-"};
        end
      end
      FMT_IPV4: begin
        if (c == ".") begin
          ok = cur.run != 7'd0 && cur.grp < 4'd3;
          s.grp = cur.grp + 4'd1; s.run = 7'd0; s.octet = 9'd0;
        end else begin
          ok = is_dig(c) && cur.run < 7'd3 && oct_w <= 12'd255;
          s.octet = oct_w[8:0]; s.run = cur.run + 7'd1;
        end
      end
      FMT_IPV6: begin
        if (p == 8'd0) begin
          if (c == ":") begin ok = 1'b1; s.pos = 8'd2; end
          else begin ok = is_hex(c); s.pos = 8'd1; s.run = 7'd1; end
        end else if (p == 8'd2) begin
          ok = c == ":"; s.pos = 8'd3;
        end else if (p == 8'd1 || p == 8'd3) begin
          if (is_hex(c)) begin
            ok = cur.run < 7'd4; s.run = cur.run + 7'd1;
          end else if (c != ":") begin
            ok = 1'b0;
          end else if (cur.run == 7'd0) begin
            ok = !(p == 8'd1 && cur.grp != 4'd7); s.pos = 8'd4;
          end else begin
            ok = cur.grp < ((p == 8'd1) ? 4'd7 : 4'd5);
            s.grp = cur.grp + 4'd1; s.run = 7'd0;
          end
        end else ok = 1'b0;
      end
      FMT_URI: begin
        case (p)
          8'd0: begin ok = is_alp(c); s.pos = 8'd1; end
          8'd1: begin
            if (c == ":") begin ok = 1'b1; s.pos = 8'd2; end
            else ok = is_aln(c) || c == "+" || c == "-" || c == ".";
          end
          8'd2: begin ok = c == "/"; s.pos = 8'd3; end
          8'd3: begin
            if (c == "/") begin ok = 1'b1; s.pos = 8'd4; end
            else begin ok = auth; s.pos = 8'd5; end
          end
          8'd4: begin ok = auth; s.pos = 8'd5; end
          8'd5: begin
            if (c == "/") begin ok = 1'b1; s.pos = 8'd6; end
            else ok = auth;
          end
          8'd6: ok = !is_spc(c);
          default: ok = 1'b0;
        endcase
      end
      FMT_DIGITS: ok = is_dig(c);
      FMT_PHONE: ok = is_dig(c) || is_spc(c) || c == "+" || c == "-" || c == "(" || c == ")";
      FMT_CARD: begin
        ok = is_dig(c);
        s.lev = mod10(5'(cur.lod) + 5'(dval));
        s.lod = mod10(5'(cur.lev) + 5'(luhn_dbl(dval)));
      end
      default: ok = 1'b0;
    endcase
    nxt = cur;
    nxt.total = s.total;
    if (!cur.miss) begin
      if (ok) nxt = s;
      else nxt.miss = 1'b1;
    end
    p = nxt.pos;
    case (fmt)
      FMT_EMAIL: acc = p == 8'd3 && nxt.grp == 4'd1 && nxt.run >= 7'd2;
      FMT_DATETIME: acc = p == S_END;
      FMT_DATE: acc = p == 8'd10;
      FMT_TIME: acc = p == S_MIN || p == S_SEC || p == S_FR || p == S_END;
      FMT_HOST: acc = p == 8'd1 && nxt.grp == 4'd0 && nxt.total <= 9'd253;
      FMT_IPV4: acc = nxt.grp == 4'd3 && nxt.run >= 7'd1;
      FMT_IPV6: acc = p == 8'd4 || ((p == 8'd1 || p == 8'd3) && nxt.run >= 7'd1
                      && (p == 8'd3 || nxt.grp == 4'd7));
      FMT_URI: acc = p == 8'd5 || p == 8'd6;
      FMT_UUID: acc = p == 8'd36;
      FMT_DIGITS, FMT_PHONE: acc = 1'b1;
      FMT_CARD: acc = nxt.total >= 9'd13 && nxt.total <= 9'd19;
      default: acc = 1'b0;
    endcase
  end
endmodule

>>> hdl/text_format_validator.sv
// Text format validator.
// The input channel carries one character per beat with a last-byte mark.
// Each beat is registered, then checked against the selected format by one
// level of recognizer logic that updates the running string state.
// The beat that carries the last byte yields one result beat: valid_res and
// error_code. Other beats yield nothing.
// Each beat passes the input register; a last byte's result then passes the
// output register. One beat is accepted every cycle while in_stall is low.
// in_stall rises only while a result waits in the output register and the
// receiver stalls with a last byte also held in the input register.
// The user writes the format register via cfg_we and cfg_data only while the
// block is idle (not enforced here); a write clears any string in progress.
// Reset selects the email format and clears all string state and valid flags.
module text_format_validator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tfv_pkg::tfv_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tfv_pkg::tfv_out_t out_data,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_data
);
  import tfv_pkg::*;

  logic [3:0] fmt_r;
  tfv_in_t    ib_r;
  logic       iv_r;
  tfv_state_t st_r, st_nxt;
  logic       acc;
  logic       adv;
  tfv_out_t   res;

  tfv_step u_step (.fmt(fmt_r), .c(ib_r.char_byte), .cur(st_r), .nxt(st_nxt), .acc(acc));

  assign adv = iv_r && !(ib_r.last_byte && out_valid && out_stall);
  assign in_stall = iv_r && !adv;

  always_comb begin
    if (st_nxt.miss || !acc) res = '{1'b0, ERR_MATCH};
    else if (fmt_r == FMT_CARD && st_nxt.lev != 4'd0) res = '{1'b0, ERR_LUHN};
    else res = '{1'b1, ERR_OK};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_EMAIL;
      iv_r <= 1'b0;
      out_valid <= 1'b0;
      st_r <= '0;
    end else begin
      if (cfg_we) begin
        fmt_r <= cfg_data;
        st_r <= '0;
      end else if (adv) begin
        st_r <= ib_r.last_byte ? '0 : st_nxt;
      end
      if (in_valid && !in_stall) begin
        iv_r <= 1'b1;
        ib_r <= in_data;
      end else if (adv) iv_r <= 1'b0;
      if (adv && ib_r.last_byte) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

>>> hdl/tfv_checker.sv
module tfv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input tfv_pkg::tfv_out_t out_data
);
  import tfv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valid_res == (out_data.error_code == ERR_OK))
    else $error("valid flag and code disagree");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error_code != 2'd3)
    else $error("bad error code");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
endmodule

bind text_format_validator tfv_checker u_chk (.*);
